/* rtl/core/gbga_pkg.sv */
// ----------------------------------------------------------------------------
// gbga_pkg
// Shared types and constants of the GB2312 glyph address generator.
// ----------------------------------------------------------------------------
package gbga_pkg;

  // Default depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Byte classes
  localparam logic [7:0] LEAD_LO  = 8'hB0;
  localparam logic [7:0] LEAD_HI  = 8'hF7;
  localparam logic [7:0] TRAIL_LO = 8'hA1;
  localparam logic [7:0] ASCII_LO = 8'h20;
  localparam logic [7:0] ASCII_HI = 8'h7E;

  // Font ROM layout
  localparam logic [12:0] ROW_CELLS  = 13'd94;
  localparam logic [12:0] HANZI_BASE = 13'd846;
  localparam logic [17:0] ASCII_BASE = 18'h3B7C0;

  // Column advance per glyph
  localparam logic [7:0] HANZI_ADVANCE = 8'd16;
  localparam logic [7:0] ASCII_ADVANCE = 8'd8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_PAGE   = 1'b0,
    CFG_START_COLUMN = 1'b1
  } cfg_idx_t;

  localparam logic [3:0] START_PAGE_RST   = 4'd1;
  localparam logic [7:0] START_COLUMN_RST = 8'd1;

  // One classified glyph, front to back
  typedef struct packed {
    logic       wide;       // 1 = 16x16 hanzi
    logic [6:0] lead_off;   // lead - 0xB0 (hanzi only)
    logic [6:0] glyph_off;  // trail - 0xA1, or char - 0x20
    logic [3:0] page;
    logic [7:0] column;
  } glyph_cmd_t;

endpackage

/* rtl/core/gbga_front.sv */
// ----------------------------------------------------------------------------
// gbga_front
// Accepts text bytes, tracks the held lead byte and the column, and pushes
// one classified glyph word per drawable byte.
// ----------------------------------------------------------------------------
module gbga_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [7:0]                          in_text_byte,
  input  logic                                cfg_we,
  input  logic [gbga_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbga_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                push,
  output gbga_pkg::glyph_cmd_t                cmd
);

  logic [3:0] start_page_r, start_page_nxt;
  logic [7:0] start_col_r, start_col_nxt;
  logic [7:0] col_r, col_nxt;
  logic [6:0] held_off_r, held_off_nxt;
  logic       lead_valid_r, lead_valid_nxt;

  logic accept;
  logic is_trail, is_lead, is_ascii;

  assign accept   = in_valid && !in_stall;
  assign is_trail = in_text_byte >= gbga_pkg::TRAIL_LO;
  assign is_lead  = (in_text_byte >= gbga_pkg::LEAD_LO) && (in_text_byte <= gbga_pkg::LEAD_HI);
  assign is_ascii = (in_text_byte >= gbga_pkg::ASCII_LO) &&
                    (in_text_byte <= gbga_pkg::ASCII_HI);

  // Classification and state update
  always_comb begin
    start_page_nxt = start_page_r;
    start_col_nxt  = start_col_r;
    col_nxt        = col_r;
    held_off_nxt   = held_off_r;
    lead_valid_nxt = lead_valid_r;
    push           = 1'b0;

    cmd.wide      = lead_valid_r && is_trail;
    cmd.lead_off  = held_off_r;
    cmd.glyph_off = cmd.wide ? 7'(in_text_byte - gbga_pkg::TRAIL_LO)
                             : 7'(in_text_byte - gbga_pkg::ASCII_LO);
    cmd.page      = start_page_r;
    cmd.column    = col_r;

    if (cfg_we) begin
      unique case (gbga_pkg::cfg_idx_t'(cfg_index))
        gbga_pkg::CFG_START_PAGE: begin
          start_page_nxt = cfg_data[3:0];
        end
        gbga_pkg::CFG_START_COLUMN: begin
          start_col_nxt = cfg_data;
          col_nxt       = cfg_data;
        end
        default: ;
      endcase
    end else if (accept) begin
      lead_valid_nxt = 1'b0;
      priority if (lead_valid_r && is_trail) begin
        push    = 1'b1;
        col_nxt = col_r + gbga_pkg::HANZI_ADVANCE;
      end else if (in_text_byte == 8'h00) begin
        // end of string
        col_nxt = start_col_r;
      end else if (is_lead) begin
        lead_valid_nxt = 1'b1;
        held_off_nxt   = 7'(in_text_byte - gbga_pkg::LEAD_LO);
      end else if (is_ascii) begin
        push    = 1'b1;
        col_nxt = col_r + gbga_pkg::ASCII_ADVANCE;
      end else begin
        // undrawable byte: skipped
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_page_r <= gbga_pkg::START_PAGE_RST;
      start_col_r  <= gbga_pkg::START_COLUMN_RST;
      col_r        <= gbga_pkg::START_COLUMN_RST;
      lead_valid_r <= 1'b0;
      held_off_r   <= '0;
    end else begin
      start_page_r <= start_page_nxt;
      start_col_r  <= start_col_nxt;
      col_r        <= col_nxt;
      lead_valid_r <= lead_valid_nxt;
      held_off_r   <= held_off_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> accept)
    else $error("glyph pushed without an accepted byte");

  a_wide_needs_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (push && cmd.wide) |-> lead_valid_r)
    else $error("hanzi glyph without a held lead");

  a_lead_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(lead_valid_r) |-> $past(accept))
    else $error("lead held without an accepted byte");
`endif

endmodule

/* rtl/core/gbga_queue.sv */
// ----------------------------------------------------------------------------
// gbga_queue
// Short register queue of glyph words between the front and the back.
// ----------------------------------------------------------------------------
module gbga_queue #(
  parameter int unsigned Depth = gbga_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  gbga_pkg::glyph_cmd_t push_data,
  input  logic                 pop,
  output logic                 full,
  output logic                 q_valid,
  output gbga_pkg::glyph_cmd_t q_data
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  gbga_pkg::glyph_cmd_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic wr_en, rd_en;

  assign full    = count_r == DepthCnt;
  assign q_valid = count_r != '0;
  assign q_data  = mem_r[rd_ptr_r];
  assign wr_en   = push && !full;
  assign rd_en   = pop && q_valid;

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DepthCnt)
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule

/* rtl/core/gbga_back.sv */
// ----------------------------------------------------------------------------
// gbga_back
// Pops glyph words, computes the font ROM address and holds the result in
// the output register.
// ----------------------------------------------------------------------------
module gbga_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  gbga_pkg::glyph_cmd_t q_data,
  output logic                 pop,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [17:0]          out_rom_address,
  output logic                 out_glyph_wide,
  output logic [3:0]           out_glyph_page,
  output logic [7:0]           out_glyph_column
);

  logic        out_valid_r, out_valid_nxt;
  logic [17:0] addr_r;
  logic        wide_r;
  logic [3:0]  page_r;
  logic [7:0]  column_r;

  logic [12:0] row_base;
  logic [12:0] glyph_idx;
  logic [17:0] addr_nxt;

  assign pop = q_valid && (!out_valid_r || !out_stall);

  // Address: hanzi glyph index * 32, or ASCII offset * 16 plus table base
  always_comb begin
    row_base  = 13'({6'd0, q_data.lead_off} * gbga_pkg::ROW_CELLS);
    glyph_idx = row_base + {6'd0, q_data.glyph_off} + gbga_pkg::HANZI_BASE;
    if (q_data.wide) begin
      addr_nxt = {glyph_idx, 5'd0};
    end else begin
      addr_nxt = {7'd0, q_data.glyph_off, 4'd0} + gbga_pkg::ASCII_BASE;
    end
  end

  // Output word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      addr_r   <= addr_nxt;
      wide_r   <= q_data.wide;
      page_r   <= q_data.page;
      column_r <= q_data.column;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rom_address  = addr_r;
  assign out_glyph_wide   = wide_r;
  assign out_glyph_page   = page_r;
  assign out_glyph_column = column_r;

endmodule

/* rtl/core/gb2312_glyph_address_gen.sv */
// ----------------------------------------------------------------------------
// gb2312_glyph_address_gen
// GB2312 / ASCII text byte stream to font ROM glyph descriptors.
// ----------------------------------------------------------------------------
// One text byte is taken per clock while in_stall is low. The front classifies
// a byte in the accepting cycle; a hanzi word (on its trail byte) or an ASCII
// word is then registered in the command queue, and from there passes the back
// address stage into the output register. The command queue (QueueDepth words)
// lets the front keep taking bytes while a result waits on out_stall; in_stall
// rises only when that queue is full. Lead bytes, end-of-string zeros and
// undrawable bytes produce no word.
module gb2312_glyph_address_gen #(
  parameter int unsigned QueueDepth = gbga_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_text_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [17:0]                     out_rom_address,
  output logic                            out_glyph_wide,
  output logic [3:0]                      out_glyph_page,
  output logic [7:0]                      out_glyph_column,
  input  logic                            cfg_we,
  input  logic [gbga_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbga_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                 push;
  gbga_pkg::glyph_cmd_t push_data;
  logic                 q_full;
  logic                 q_valid;
  gbga_pkg::glyph_cmd_t q_data;
  logic                 pop;

  assign in_stall = q_full;

  // Front: classify bytes
  gbga_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .cmd          (push_data)
  );

  // Queue between front and back
  gbga_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // Back: address and output register
  gbga_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .pop              (pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_rom_address  (out_rom_address),
    .out_glyph_wide   (out_glyph_wide),
    .out_glyph_page   (out_glyph_page),
    .out_glyph_column (out_glyph_column)
  );

endmodule

/* bench/gb2312_glyph_address_gen_tb.sv */
// ----------------------------------------------------------------------------
// gb2312_glyph_address_gen_tb
// Streams GB2312 and ASCII text bytes through the glyph address generator and
// checks every glyph word against an in-bench model of the byte decoder,
// across several page and column settings, with random gaps and stalls.
// ----------------------------------------------------------------------------
module gb2312_glyph_address_gen_tb;

  localparam int unsigned HANZI_BYTES   = 32;
  localparam int unsigned ASCII_BYTES   = 16;
  localparam int unsigned SETTLE_CYCLES = 8;     // pipeline plus queue, with margin
  localparam int unsigned LONG_HOLD     = 80;    // receiver hold-off for back-pressure
  localparam int unsigned IDLE_LIMIT    = 2000;  // watchdog, cycles without progress
  localparam int unsigned RANDOM_BYTES  = 1800;

  // One glyph word as the block emits it
  typedef struct packed {
    logic [17:0] rom_address;
    logic        wide;
    logic [3:0]  page;
    logic [7:0]  column;
  } glyph_word_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [7:0]                      in_text_byte;
  logic                            out_valid;
  logic                            out_stall;
  logic [17:0]                     out_rom_address;
  logic                            out_glyph_wide;
  logic [3:0]                      out_glyph_page;
  logic [7:0]                      out_glyph_column;
  logic                            cfg_we;
  logic [gbga_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gbga_pkg::CFG_DATA_W-1:0] cfg_data;

  // Decoder model state
  logic [3:0]  mdl_page;
  logic [7:0]  mdl_start_col;
  logic [7:0]  mdl_lead;
  logic        mdl_lead_held;
  logic [7:0]  mdl_col;

  glyph_word_t pending_glyphs[$];

  // Knobs and counters
  bit          in_gaps_on;
  bit          out_stalls_on;
  bit          hold_request;
  int unsigned err_cnt;
  int unsigned bytes_sent;
  int unsigned hanzi_seen;
  int unsigned ascii_seen;
  int unsigned in_stall_cycles;
  int unsigned settings_used;
  int unsigned idle_cycles;

  gb2312_glyph_address_gen u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rom_address  (out_rom_address),
    .out_glyph_wide   (out_glyph_wide),
    .out_glyph_page   (out_glyph_page),
    .out_glyph_column (out_glyph_column),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Model of the byte decoder: updates state, queues the glyph word if any
  function automatic void predict_glyph(input logic [7:0] c);
    int unsigned glyph_idx;
    glyph_word_t w;
    if (mdl_lead_held) begin
      mdl_lead_held = 1'b0;
      if (c >= gbga_pkg::TRAIL_LO) begin
        glyph_idx = (int'(mdl_lead) - int'(gbga_pkg::LEAD_LO)) * int'(gbga_pkg::ROW_CELLS)
                  + (int'(c) - int'(gbga_pkg::TRAIL_LO)) + int'(gbga_pkg::HANZI_BASE);
        w.rom_address = 18'(glyph_idx * HANZI_BYTES);
        w.wide        = 1'b1;
        w.page        = mdl_page;
        w.column      = mdl_col;
        pending_glyphs.push_back(w);
        mdl_col = mdl_col + gbga_pkg::HANZI_ADVANCE;
        return;
      end
    end
    if (c == 8'h00) begin
      // end of string
      mdl_lead_held = 1'b0;
      mdl_col       = mdl_start_col;
    end else if (c >= gbga_pkg::LEAD_LO && c <= gbga_pkg::LEAD_HI) begin
      mdl_lead      = c;
      mdl_lead_held = 1'b1;
    end else if (c >= gbga_pkg::ASCII_LO && c <= gbga_pkg::ASCII_HI) begin
      w.rom_address = 18'((int'(c) - int'(gbga_pkg::ASCII_LO)) * ASCII_BYTES)
                    + gbga_pkg::ASCII_BASE;
      w.wide        = 1'b0;
      w.page        = mdl_page;
      w.column      = mdl_col;
      pending_glyphs.push_back(w);
      mdl_col = mdl_col + gbga_pkg::ASCII_ADVANCE;
    end
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!in_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Send one text byte; hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (in_stall);
    predict_glyph(b);
    bytes_sent++;
  endtask

  // Stop sending and wait until every glyph word is out and the pipe is empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; block must be idle
  task automatic cfg_write(input gbga_pkg::cfg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == gbga_pkg::CFG_START_PAGE) begin
      mdl_page = val[3:0];
    end else begin
      mdl_start_col = val;
      mdl_col       = val;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_layout(input logic [7:0] page, input logic [7:0] column);
    drain();
    cfg_write(gbga_pkg::CFG_START_PAGE, page);
    cfg_write(gbga_pkg::CFG_START_COLUMN, column);
    settings_used++;
  endtask

  // Random text: mostly well-formed glyphs, some broken pairs and noise
  task automatic send_text_token();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      send_byte(8'($urandom_range(gbga_pkg::ASCII_LO, gbga_pkg::ASCII_HI)));
    end else if (r < 75) begin
      send_byte(8'($urandom_range(gbga_pkg::LEAD_LO, gbga_pkg::LEAD_HI)));
      send_byte(8'($urandom_range(gbga_pkg::TRAIL_LO, 8'hFF)));
    end else if (r < 80) begin
      send_byte(8'h00);
    end else if (r < 90) begin
      send_byte(8'($urandom_range(gbga_pkg::LEAD_LO, gbga_pkg::LEAD_HI)));
      send_byte(8'($urandom_range(8'h00, 8'hA0)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Directed bytes at reset settings: field extremes and each special case
  task automatic test_directed();
    logic [7:0] seq[$];
    seq = '{8'h20, 8'h7E, 8'h41,              // ASCII extremes
            8'hB0, 8'hA1, 8'hF7, 8'hFF,       // lowest and highest hanzi
            8'hC5, 8'hD0,
            8'h01, 8'h1F, 8'h7F, 8'h80,       // undrawable, no lead held
            8'hA1, 8'hAF, 8'hF8, 8'hFF,
            8'hB0, 8'hA0,                     // lead without trail
            8'hF7, 8'h5A,                     // lead then ASCII
            8'hB5, 8'hC0,                     // a lead byte used as trail
            8'hB0, 8'h00,                     // lead cut by end of string
            8'h33, 8'h00, 8'h7E};
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    foreach (seq[i]) send_byte(seq[i]);
    drain();
  endtask

  // Several layouts, extremes and out-of-range values included
  task automatic test_layout_sweep();
    logic [7:0] pages[$];
    logic [7:0] cols[$];
    pages = '{8'd8, 8'd1, 8'd4, 8'd15, 8'd0, 8'hF3};
    cols  = '{8'd192, 8'd1, 8'd100, 8'd255, 8'd0, 8'd250};
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    foreach (pages[i]) begin
      set_layout(pages[i], cols[i]);
      repeat (12) send_text_token();
    end
    drain();
  endtask

  // A held lead survives a register write; the trail uses the new layout
  task automatic test_lead_across_write();
    drain();
    send_byte(8'hB8);
    drain();
    cfg_write(gbga_pkg::CFG_START_COLUMN, 8'd50);
    cfg_write(gbga_pkg::CFG_START_PAGE, 8'd6);
    send_byte(8'hC3);
    send_byte(8'h21);
    drain();
  endtask

  // Receiver holds off long while the sender keeps pushing
  task automatic test_back_pressure();
    drain();
    in_gaps_on   = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_byte(8'($urandom_range(gbga_pkg::ASCII_LO, gbga_pkg::ASCII_HI)));
    drain();
  endtask

  // Long random run in segments with changing layout and idling
  task automatic test_random_text();
    int unsigned seg_end;
    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0)
        set_layout(8'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      else
        set_layout(8'($urandom_range(1, 8)), 8'($urandom_range(1, 192)));
      in_gaps_on    = $urandom_range(0, 3) != 0;
      out_stalls_on = $urandom_range(0, 3) != 0;
      seg_end = bytes_sent + 150;
      while (bytes_sent < seg_end) send_text_token();
    end
    drain();
  endtask

  // Receiver: random stalls, long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned r;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!out_stalls_on) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else begin
          out_stall  <= 1'b1;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        end
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    glyph_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_glyphs.size() == 0) begin
        $display("%0t: unexpected glyph word addr=%h wide=%b page=%0d col=%0d", $time,
                 out_rom_address, out_glyph_wide, out_glyph_page, out_glyph_column);
        err_cnt++;
      end else begin
        w = pending_glyphs.pop_front();
        if (w.wide) hanzi_seen++; else ascii_seen++;
        if (out_rom_address !== w.rom_address) begin
          $display("%0t: rom_address expected %h actual %h", $time, w.rom_address,
                   out_rom_address);
          err_cnt++;
        end
        if (out_glyph_wide !== w.wide) begin
          $display("%0t: glyph_wide expected %b actual %b", $time, w.wide, out_glyph_wide);
          err_cnt++;
        end
        if (out_glyph_page !== w.page) begin
          $display("%0t: glyph_page expected %0d actual %0d", $time, w.page,
                   out_glyph_page);
          err_cnt++;
        end
        if (out_glyph_column !== w.column) begin
          $display("%0t: glyph_column expected %0d actual %0d", $time, w.column,
                   out_glyph_column);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any progress
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) in_stall_cycles++;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d words outstanding", $time,
               IDLE_LIMIT, pending_glyphs.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Test sequence
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_text_byte  = 8'h00;
    cfg_we        = 1'b0;
    cfg_index     = gbga_pkg::CFG_START_PAGE;
    cfg_data      = '0;
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    hold_request  = 1'b0;
    err_cnt       = 0;
    bytes_sent    = 0;
    hanzi_seen    = 0;
    ascii_seen    = 0;
    settings_used = 1;
    idle_cycles   = 0;
    in_stall_cycles = 0;
    mdl_page      = gbga_pkg::START_PAGE_RST;
    mdl_start_col = gbga_pkg::START_COLUMN_RST;
    mdl_col       = gbga_pkg::START_COLUMN_RST;
    mdl_lead      = 8'h00;
    mdl_lead_held = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_layout_sweep();
    test_lead_across_write();
    test_back_pressure();
    test_random_text();
    drain();

    $display("Sent %0d text bytes over %0d page/column settings; checked %0d hanzi and",
             bytes_sent, settings_used, hanzi_seen);
    $display("%0d ASCII glyph words; input stalled for %0d cycles.", ascii_seen,
             in_stall_cycles);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* gb2312_glyph_address_gen.f */
rtl/core/gbga_pkg.sv
rtl/core/gbga_front.sv
rtl/core/gbga_queue.sv
rtl/core/gbga_back.sv
rtl/core/gb2312_glyph_address_gen.sv
bench/gb2312_glyph_address_gen_tb.sv
